### rtl/scba_pkg.sv
// Package with shared types and codes of the size class block allocator.
package scba_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_RESIZE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SOFT  = 2'd1,
    ST_NOMEM = 2'd2,
    ST_MOVE  = 2'd3
  } status_e;

  localparam int unsigned HdrBytes  = 16;
  localparam int unsigned PageRound = 4095;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] req_size;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] pointer;
    logic [12:0] usable_bytes;
    logic [3:0]  size_class;
  } rsp_t;

endpackage

### rtl/scba_req_if.sv
// Valid/ready channel interface that carries one request item.
interface scba_req_if;
  logic                 valid;
  logic                 ready;
  scba_pkg::req_t       payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/scba_rsp_if.sv
// Valid/ready channel interface that carries one result item.
interface scba_rsp_if;
  logic                 valid;
  logic                 ready;
  scba_pkg::rsp_t       payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/scba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module scba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/size_class_block_allocator.sv
// Top level of the size class block allocator.
//
//  channel   direction  handshake        payload
//  req       in         valid/ready      operation, req_size, address
//  rsp       out        valid/ready      status, pointer, usable_bytes, size_class
//  cfg       in         write enable     heap_base
//
// The work on a request runs in steps once it is accepted: in the accepting cycle the
// slot address is decoded and the block class and next link of the head are read
// from the synchronous RAMs; in S_EXEC the result is formed, the state updated
// and the item moved into the output register, from which it is shown in S_OUT.
// The next request is taken in the cycle after the result leaves; a stalled result
// holds the block in S_OUT, its result state.
// Reset is asynchronous and clears all free lists and the bump state; the slot
// RAMs are not cleared, and the block does not enforce that a slot is written before
// its class is used: the user must release, query or resize only blocks handed out.
module size_class_block_allocator #(
  parameter int unsigned CLASS_COUNT     = 9,
  parameter int unsigned ARENA_BYTES     = 1048576,
  parameter int unsigned HEAP_ARENAS     = 4,
  parameter int unsigned MIN_CLASS_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  scba_req_if.sink    req,
  scba_rsp_if.source  rsp
);
  import scba_pkg::*;

  localparam longint unsigned WindowBytes = longint'(HEAP_ARENAS) * ARENA_BYTES;
  localparam int unsigned     Slots       = int'(WindowBytes / MIN_CLASS_BYTES);
  localparam int unsigned     SlotW       = $clog2(Slots);
  localparam int unsigned     MinShift    = $clog2(MIN_CLASS_BYTES);
  localparam int unsigned     OffW        = $clog2(WindowBytes) + 1;
  localparam int unsigned     ArenaW      = $clog2(ARENA_BYTES) + 1;
  localparam int unsigned     ArenaCntW   = $clog2(HEAP_ARENAS + 1);
  localparam int unsigned     ClsW        = 4;
  localparam int unsigned     HeadW       = SlotW + 1;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_e;

  state_e               state_q;
  req_t                 req_q;
  rsp_t                 rsp_q;
  logic [31:0]          heap_base_q;
  logic [HeadW-1:0]     heads_q [CLASS_COUNT];
  logic [OffW-1:0]      bump_q;
  logic [ArenaW-1:0]    remain_q;
  logic [ArenaCntW-1:0] used_q;

  // Decode of the incoming address (first cycle) kept for the second.
  logic [31:0]      off_w;
  logic             hit_w;
  logic [SlotW-1:0] slot_w, slot_q;
  logic             hit_q;

  assign off_w  = req.payload.address - 32'(HdrBytes) - heap_base_q;
  assign hit_w  = (64'(off_w) < WindowBytes) && (off_w[MinShift-1:0] == '0);
  assign slot_w = SlotW'(off_w >> MinShift);

  // Alloc class for the requested size, also computed in the first cycle.
  logic [32:0] need_w;
  logic [3:0]  acls_w, acls_q;
  logic        big_w, big_q, near_w, near_q;
  always_comb begin
    logic [31:0] n;
    n      = (req.payload.req_size == '0) ? 32'd1 : req.payload.req_size;
    near_w = n > (32'hFFFF_FFFF - 32'(HdrBytes) - 32'(PageRound));
    need_w = 33'(n) + 33'(HdrBytes);
    acls_w = ClsW'(CLASS_COUNT);
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if ((40'(MIN_CLASS_BYTES) << c) >= 40'(need_w)) acls_w = ClsW'(c);
    end
    big_w = acls_w >= ClsW'(CLASS_COUNT);
  end

  // Head of the alloc class picked at acceptance; its link is read from RAM.
  logic [HeadW-1:0] ahead_w, ahead_q;
  assign ahead_w = big_w ? '0 : heads_q[acls_w];

  logic              acc_w;
  assign req.ready = (state_q == S_IDLE);
  assign acc_w     = req.valid && req.ready;

  // RAM ports.
  logic             we_link, we_cls;
  logic [SlotW-1:0] wa_link, wa_cls;
  logic [SlotW-1:0] wd_link;
  logic [ClsW-1:0]  wd_cls;
  logic [SlotW-1:0] link_rd;
  logic [ClsW-1:0]  cls_rd;

  scba_ram #(.Width(SlotW), .Depth(Slots)) u_links (
    .clk_i, .we_i(we_link), .waddr_i(wa_link), .wdata_i(wd_link),
    .raddr_i(SlotW'(ahead_w - 1'b1)), .rdata_o(link_rd)
  );
  scba_ram #(.Width(ClsW), .Depth(Slots)) u_classes (
    .clk_i, .we_i(we_cls), .waddr_i(wa_cls), .wdata_i(wd_cls),
    .raddr_i(slot_w), .rdata_o(cls_rd)
  );

  // Second cycle: everything decided from registered request and RAM data.
  logic [3:0]        oc;          // class of the addressed block
  logic              do_alloc, do_push, alloc_ok;
  logic [1:0]        alloc_st;
  logic [SlotW-1:0]  aslot;
  logic              pop;
  logic [OffW-1:0]   bump_d;
  logic [ArenaW-1:0] remain_d;
  logic [ArenaCntW-1:0] used_d;
  logic [HeadW-1:0]  newhead;
  rsp_t              rsp_d;

  function automatic logic [12:0] usable(input logic [3:0] c);
    return 13'((32'(MIN_CLASS_BYTES) << c) - 32'(HdrBytes));
  endfunction

  always_comb begin
    logic [OffW-1:0]   off;
    logic [OffW:0]     sz;
    logic              isnull, fits;
    oc       = (cls_rd < ClsW'(CLASS_COUNT)) ? cls_rd : '0;
    isnull   = req_q.address == '0;
    do_alloc = 1'b0;
    do_push  = 1'b0;
    alloc_ok = 1'b0;
    alloc_st = ST_DONE;
    aslot    = '0;
    pop      = 1'b0;
    bump_d   = bump_q;
    remain_d = remain_q;
    used_d   = used_q;
    newhead  = '0;
    off      = '0;
    sz       = (OffW+1)'(MIN_CLASS_BYTES) << acls_q;
    fits     = 33'(req_q.req_size) <= 33'(usable(oc));
    rsp_d    = '0;
    rsp_d.status = ST_DONE;

    if (req_q.operation == OP_ALLOC || (req_q.operation == OP_RESIZE && isnull)) begin
      do_alloc = 1'b1;
    end else if (isnull) begin
      rsp_d.status = ST_DONE;
    end else if (!hit_q) begin
      rsp_d.status = ST_SOFT;
    end else if (req_q.operation == OP_FREE ||
                 (req_q.operation == OP_RESIZE && req_q.req_size == '0)) begin
      do_push = 1'b1;
      rsp_d.size_class = oc;
      rsp_d.usable_bytes = usable(oc);
    end else if (req_q.operation == OP_QUERY || fits) begin
      rsp_d.pointer = req_q.address;
      rsp_d.size_class = oc;
      rsp_d.usable_bytes = usable(oc);
    end else begin
      do_alloc = 1'b1;
    end

    if (do_alloc) begin
      if (near_q) begin
        alloc_st = ST_NOMEM;
      end else if (big_q) begin
        alloc_st = ST_SOFT;
      end else if (ahead_q != '0) begin
        pop      = 1'b1;
        alloc_ok = 1'b1;
        aslot    = SlotW'(ahead_q - 1'b1);
        newhead  = (link_rd == aslot) ? '0 : HeadW'(link_rd) + 1'b1;
      end else if (sz > (OffW+1)'(ARENA_BYTES)) begin
        alloc_st = ST_NOMEM;
      end else begin
        alloc_ok = 1'b1;
        off = bump_q;
        if ((OffW+1)'(remain_q) < sz) begin
          if (used_q >= ArenaCntW'(HEAP_ARENAS)) begin
            alloc_ok = 1'b0;
            alloc_st = ST_NOMEM;
          end else begin
            off      = OffW'(used_q) * OffW'(ARENA_BYTES);
            remain_d = ArenaW'(ARENA_BYTES);
            used_d   = used_q + 1'b1;
          end
        end
        if (alloc_ok) begin
          bump_d   = off + OffW'(sz);
          remain_d = remain_d - ArenaW'(sz);
          aslot    = SlotW'(off >> MinShift);
        end
      end
      if (alloc_ok) begin
        rsp_d.status       = (req_q.operation == OP_RESIZE && !isnull) ? ST_MOVE : ST_DONE;
        rsp_d.pointer      = heap_base_q + (32'(aslot) << MinShift) + 32'(HdrBytes);
        rsp_d.size_class   = acls_q;
        rsp_d.usable_bytes = usable(acls_q);
        do_push            = !isnull && req_q.operation == OP_RESIZE;
      end else begin
        rsp_d.status = alloc_st;
      end
    end

    we_cls  = (state_q == S_EXEC) && do_alloc && alloc_ok;
    wa_cls  = aslot;
    wd_cls  = acls_q;
    we_link = (state_q == S_EXEC) && do_push;
    wa_link = slot_q;
  end

  // The link written on a push is the old head of the released block's class,
  // taken after any pop of the same cycle has updated it.
  always_comb begin
    logic [HeadW-1:0] h;
    h = heads_q[oc];
    if (pop && acls_q == oc) h = newhead;
    wd_link = (h != '0) ? SlotW'(h - 1'b1) : slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_q       <= '0;
      heap_base_q <= '0;
      bump_q      <= '0;
      remain_q    <= '0;
      used_q      <= '0;
      for (int c = 0; c < CLASS_COUNT; c++) heads_q[c] <= '0;
    end else begin
      if (cfg_we_i) heap_base_q <= cfg_wdata_i;
      unique case (state_q)
        S_IDLE: begin
          if (acc_w) state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q  <= S_OUT;
          rsp_q    <= rsp_d;
          bump_q   <= bump_d;
          remain_q <= remain_d;
          used_q   <= used_d;
          if (pop) heads_q[acls_q] <= newhead;
          if (do_push) heads_q[oc] <= HeadW'(slot_q) + 1'b1;
        end
        S_OUT: begin
          if (rsp.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_w) begin
      req_q   <= req.payload;
      slot_q  <= slot_w;
      hit_q   <= hit_w;
      acls_q  <= acls_w;
      big_q   <= big_w;
      near_q  <= near_w;
      ahead_q <= ahead_w;
    end
  end

  assign rsp.valid   = (state_q == S_OUT);
  assign rsp.payload = rsp_q;
endmodule

### rtl/scba_checker.sv
// Port-level checker for the size class block allocator, bound to the top level.
module scba_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input scba_pkg::rsp_t rsp_payload
);
  import scba_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("result item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready)
    else $error("request taken while a result waits");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> ##1 rsp_valid)
    else $error("result missing two cycles after a request");

  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_payload.status == ST_SOFT || rsp_payload.status == ST_NOMEM)
      |-> rsp_payload.pointer == '0 && rsp_payload.size_class == '0)
    else $error("failed request returned a block");
endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

### test/tb_size_class_block_allocator.sv
// Testbench for the size class block allocator: directed table, random phases, self-checking.
module tb_size_class_block_allocator;
  import scba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The heap is four arenas of 1 MiB, cut into 32-byte slots.
  localparam int unsigned ClassCount = 9;
  localparam longint unsigned ArenaSize = 64'd1048576;
  localparam int unsigned ArenaCount = 4;
  localparam longint unsigned WindowSize = ArenaSize * ArenaCount;
  localparam int unsigned SlotCount = 131072;
  localparam longint unsigned SizeLimit = 64'hFFFF_FFFF - HdrBytes - PageRound;
  localparam int unsigned WatchdogLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  scba_req_if req ();
  scba_rsp_if rsp ();

  size_class_block_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req),
    .rsp        (rsp)
  );

  // The clock runs with a period of 2 ns.
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow state of the allocator, kept in step with every accepted item.
  logic [31:0]     heap_base_q;
  int unsigned     free_head_q [ClassCount];
  int unsigned     free_link_q [SlotCount];
  logic [3:0]      slot_class_q [SlotCount];
  longint unsigned carve_offset_q;
  longint unsigned carve_left_q;
  int unsigned     arenas_open_q;

  // Slot indexes that were ever handed out; only these are released, queried or resized,
  // so the block never uses the class of a slot that was not written.
  int unsigned     handed_slots [$];

  rsp_t            pending_results [$];

  int unsigned     mismatches;
  int unsigned     items_sent;
  int unsigned     results_seen;
  int unsigned     nomem_seen;
  int unsigned     soft_seen;
  int unsigned     moves_seen;
  int unsigned     quiet_cycles;
  bit              idle_off;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t e;
  } table_row_t;

  table_row_t directed_rows [$];

  function automatic longint unsigned class_size(int unsigned c);
    return longint'(32) << c;
  endfunction

  // Allocates a block of n bytes in the shadow state and returns its status.
  function automatic status_e carve_block(longint unsigned n, output logic [31:0] ptr,
                                          output int unsigned cls);
    longint unsigned need;
    longint unsigned sz;
    longint unsigned off;
    int unsigned     idx;
    int unsigned     link;
    int unsigned     c;
    ptr = '0;
    cls = 0;
    c = 0;
    if (n == 0) n = 1;
    if (n > SizeLimit) return ST_NOMEM;
    need = n + HdrBytes;
    while (c < ClassCount && class_size(c) < need) c++;
    if (c >= ClassCount) return ST_SOFT;
    if (free_head_q[c] != 0) begin
      idx = free_head_q[c] - 1;
      link = free_link_q[idx];
      free_head_q[c] = (link == idx) ? 0 : link + 1;
    end else begin
      sz = class_size(c);
      if (carve_left_q < sz) begin
        // The arena tail is too short, so it is abandoned and the next arena opened.
        if (arenas_open_q >= ArenaCount) return ST_NOMEM;
        carve_offset_q = longint'(arenas_open_q) * ArenaSize;
        carve_left_q = ArenaSize;
        arenas_open_q++;
      end
      off = carve_offset_q;
      carve_offset_q += sz;
      carve_left_q -= sz;
      idx = int'(off / 32);
    end
    slot_class_q[idx] = c[3:0];
    handed_slots.push_back(idx);
    ptr = heap_base_q + idx * 32 + HdrBytes;
    cls = c;
    return ST_DONE;
  endfunction

  function automatic void push_free(int unsigned idx, int unsigned c);
    free_link_q[idx] = (free_head_q[c] != 0) ? free_head_q[c] - 1 : idx;
    free_head_q[c] = idx + 1;
  endfunction

  function automatic rsp_t block_result(status_e st, logic [31:0] ptr, int unsigned c,
                                        bit has);
    rsp_t o;
    o.status = st;
    o.pointer = ptr;
    o.usable_bytes = has ? 13'(class_size(c) - HdrBytes) : '0;
    o.size_class = has ? c[3:0] : '0;
    return o;
  endfunction

  // Works out the result of one request and applies its effect to the shadow state.
  function automatic rsp_t allocator_result(req_t r);
    logic [31:0]  ptr;
    logic [31:0]  off;
    int unsigned  c;
    int unsigned  nc;
    int unsigned  idx;
    status_e      st;
    op_e          op;
    op = op_e'(r.operation);
    if (op == OP_ALLOC || (op == OP_RESIZE && r.address == 0)) begin
      st = carve_block(r.req_size, ptr, c);
      return block_result(st, (st == ST_DONE) ? ptr : 32'd0, c, st == ST_DONE);
    end
    if (r.address == 0) return block_result(ST_DONE, '0, 0, 1'b0);
    off = r.address - HdrBytes - heap_base_q;
    if (off >= WindowSize || off[4:0] != 0) return block_result(ST_SOFT, '0, 0, 1'b0);
    idx = off >> 5;
    c = (slot_class_q[idx] < ClassCount) ? slot_class_q[idx] : 0;
    case (op)
      OP_FREE: begin
        push_free(idx, c);
        return block_result(ST_DONE, '0, c, 1'b1);
      end
      OP_QUERY: begin
        return block_result(ST_DONE, r.address, c, 1'b1);
      end
      default: begin
        if (r.req_size == 0) begin
          push_free(idx, c);
          return block_result(ST_DONE, '0, c, 1'b1);
        end
        if (r.req_size <= class_size(c) - HdrBytes)
          return block_result(ST_DONE, r.address, c, 1'b1);
        st = carve_block(r.req_size, ptr, nc);
        if (st != ST_DONE) return block_result(st, '0, 0, 1'b0);
        push_free(idx, c);
        return block_result(ST_MOVE, ptr, nc, 1'b1);
      end
    endcase
  endfunction

  // Gap lengths: mostly none or short, now and then long.
  function automatic int unsigned idle_gap();
    int unsigned p;
    if (idle_off) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] slot_address(int unsigned idx);
    return heap_base_q + idx * 32 + HdrBytes;
  endfunction

  function automatic logic [31:0] random_handed_address();
    return slot_address(handed_slots[$urandom_range(0, handed_slots.size() - 1)]);
  endfunction

  // A size that falls into a random class, with now and then an extreme one.
  function automatic logic [31:0] random_size(int unsigned top_class);
    int unsigned p;
    int unsigned c;
    p = $urandom_range(0, 99);
    if (p < 3) return 32'd0;
    if (p < 6) return $urandom();
    if (p < 8) return $urandom_range(32'hFFFF_EFF0, 32'hFFFF_FFFF);
    if (p < 11) return $urandom_range(8177, 9000);
    c = $urandom_range(0, top_class);
    return $urandom_range((c == 0) ? 1 : 32'(class_size(c - 1)) - HdrBytes + 1,
                          32'(class_size(c)) - HdrBytes);
  endfunction

  // An address that is not a slot header inside the window.
  function automatic logic [31:0] foreign_address();
    logic [31:0] off;
    if ($urandom_range(0, 1) == 0)
      off = $urandom_range(0, SlotCount - 1) * 32 + $urandom_range(1, 31);
    else
      off = $urandom_range(32'(WindowSize), 32'hFFFF_FFFF);
    return off + HdrBytes + heap_base_q;
  endfunction

  function automatic req_t random_request(int unsigned top_class, int unsigned alloc_pct);
    req_t        r;
    int unsigned p;
    r.operation = OP_ALLOC;
    r.req_size = random_size(top_class);
    r.address = '0;
    p = $urandom_range(0, 99);
    if (p < alloc_pct || handed_slots.size() == 0) return r;
    p = $urandom_range(0, 99);
    if (p < 10) begin
      // Noise: null and foreign addresses, with junk sizes.
      r.operation = 2'($urandom_range(1, 3));
      r.req_size = $urandom();
      r.address = ($urandom_range(0, 2) == 0) ? 32'd0 : foreign_address();
    end else if (p < 50) begin
      r.operation = OP_FREE;
      r.req_size = $urandom();
      r.address = random_handed_address();
    end else if (p < 65) begin
      r.operation = OP_QUERY;
      r.req_size = $urandom();
      r.address = random_handed_address();
    end else begin
      r.operation = OP_RESIZE;
      r.address = random_handed_address();
    end
    return r;
  endfunction

  task automatic drive_item(req_t r, bit typed, rsp_t e);
    int unsigned gap;
    rsp_t        predicted;
    gap = idle_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.payload <= r;
    do @(posedge clk_i); while (!req.ready);
    predicted = allocator_result(r);
    pending_results.push_back(typed ? e : predicted);
    items_sent++;
  endtask

  // Lets the sender rest until every result has come back.
  task automatic drain_results();
    @(posedge clk_i);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_heap_base(logic [31:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    heap_base_q = value;
  endtask

  task automatic run_random(int unsigned count, int unsigned top_class, int unsigned alloc_pct);
    req_t r;
    rsp_t none;
    none = '0;
    for (int unsigned i = 0; i < count; i++) begin
      idle_off = (i % 200) < 40;
      r = random_request(top_class, alloc_pct);
      if (r.operation == OP_RESIZE && r.address != 0) r.req_size = random_size(top_class);
      drive_item(r, 1'b0, none);
    end
    idle_off = 1'b0;
  endtask

  function automatic void add_row(op_e op, logic [31:0] sz, logic [31:0] addr, bit typed,
                                  status_e st = ST_DONE, logic [31:0] ptr = '0,
                                  logic [12:0] usable = '0, logic [3:0] cls = '0);
    table_row_t row;
    row.r.operation = op;
    row.r.req_size = sz;
    row.r.address = addr;
    row.typed = typed;
    row.e.status = st;
    row.e.pointer = ptr;
    row.e.usable_bytes = usable;
    row.e.size_class = cls;
    directed_rows.push_back(row);
  endfunction

  // Result side: random back-pressure and the comparison with the oldest expectation.
  int unsigned stall_left;
  initial begin
    rsp.ready = 1'b0;
    stall_left = 0;
  end

  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rsp.valid && rsp.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", rsp.payload);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.status == ST_NOMEM) nomem_seen++;
        if (exp_r.status == ST_SOFT) soft_seen++;
        if (exp_r.status == ST_MOVE) moves_seen++;
        if (rsp.payload.status !== exp_r.status || rsp.payload.pointer !== exp_r.pointer ||
            rsp.payload.usable_bytes !== exp_r.usable_bytes ||
            rsp.payload.size_class !== exp_r.size_class) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d ptr=%h us=%0d cls=%0d, got st=%0d ptr=%h us=%0d cls=%0d",
                     exp_r.status, exp_r.pointer, exp_r.usable_bytes, exp_r.size_class,
                     rsp.payload.status, rsp.payload.pointer, rsp.payload.usable_bytes,
                     rsp.payload.size_class);
        end
      end
    end
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else begin
      stall_left = idle_gap();
      rsp.ready <= (stall_left == 0);
    end
  end

  // Watchdog: too long without any item moving on either side ends the run.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    req.valid <= 1'b0;
    req.payload <= '0;
    quiet_cycles = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    nomem_seen = 0;
    soft_seen = 0;
    moves_seen = 0;
    idle_off = 1'b0;
    heap_base_q = '0;
    foreach (free_head_q[c]) free_head_q[c] = 0;
    carve_offset_q = 0;
    carve_left_q = 0;
    arenas_open_q = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with the heap window at its reset base of zero.
    add_row(OP_ALLOC, 32'd0, '0, 1'b1, ST_DONE, 32'd16, 13'd16, 4'd0);
    add_row(OP_ALLOC, 32'd8176, '0, 1'b1, ST_DONE, 32'd48, 13'd8176, 4'd8);
    add_row(OP_ALLOC, 32'd8177, '0, 1'b1, ST_SOFT);
    add_row(OP_ALLOC, 32'hFFFF_FFFF, '0, 1'b1, ST_NOMEM);
    add_row(OP_ALLOC, 32'hFFFF_EFF1, '0, 1'b1, ST_NOMEM);
    add_row(OP_ALLOC, 32'hFFFF_EFF0, '0, 1'b1, ST_SOFT);
    add_row(OP_FREE, 32'hFFFF_FFFF, 32'd0, 1'b1, ST_DONE);
    add_row(OP_QUERY, 32'd0, 32'd0, 1'b1, ST_DONE);
    add_row(OP_QUERY, 32'd0, 32'd16, 1'b1, ST_DONE, 32'd16, 13'd16, 4'd0);
    add_row(OP_FREE, 32'd0, 32'd17, 1'b1, ST_SOFT);
    add_row(OP_QUERY, 32'd0, 32'h0040_0010, 1'b1, ST_SOFT);
    add_row(OP_RESIZE, 32'd5, 32'hFFFF_FFFF, 1'b1, ST_SOFT);
    add_row(OP_RESIZE, 32'd16, 32'd16, 1'b0);
    add_row(OP_RESIZE, 32'd100, 32'd16, 1'b0);
    add_row(OP_RESIZE, 32'd50, 32'd0, 1'b0);
    add_row(OP_RESIZE, 32'd0, 32'd48, 1'b0);
    add_row(OP_ALLOC, 32'd8000, '0, 1'b0);
    add_row(OP_RESIZE, 32'd9000, 32'd48, 1'b0);
    add_row(OP_RESIZE, 32'hFFFF_FFFF, 32'd48, 1'b0);
    add_row(OP_FREE, 32'd0, 32'd48, 1'b0);
    for (int unsigned c = 1; c < 8; c++)
      add_row(OP_ALLOC, 32'(class_size(c)) - HdrBytes, '0, 1'b0);
    foreach (directed_rows[i])
      drive_item(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].e);

    // Mixed traffic with a random window, pausing half-way until all results are back.
    write_heap_base($urandom());
    run_random(250, 8, 45);
    drain_results();
    run_random(250, 8, 45);

    // Mostly allocations, of sizes from every class, at the lowest base.
    write_heap_base(32'h0000_0000);
    run_random(650, 8, 85);

    // Mixed traffic again with the window at the top of the address space.
    write_heap_base(32'hFFFF_FFFF);
    run_random(650, 6, 40);

    drain_results();
    repeat (10) @(posedge clk_i);
    $display("%0d request items, %0d results: %0d out of memory, %0d software, %0d moves",
             items_sent, results_seen, nomem_seen, soft_seen, moves_seen);
    $display("heap bases covered: reset, random, lowest and highest");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/scba_pkg.sv
rtl/scba_req_if.sv
rtl/scba_rsp_if.sv
rtl/scba_ram.sv
rtl/size_class_block_allocator.sv
rtl/scba_checker.sv
test/tb_size_class_block_allocator.sv
